// ----- rtl/core/pplt_pkg.sv -----
package pplt_pkg;

  localparam int FRAC_BITS = 8;

  localparam int COORD_W   = 16;
  localparam int ARC_W     = 24;
  localparam int D2_W      = ARC_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_Q    = 15;
  localparam int MUL_A_W   = 19;
  localparam int MUL_B_W   = 25;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int NUM_W     = 50;
  localparam int DSH_W     = PROD_W + 16;
  localparam int QUO_W     = 17;
  localparam int DCNT_W    = 5;
  localparam int CURV_SH   = 13;

  localparam logic [COORD_W-1:0] LOOKAHEAD_RST = COORD_W'(40 << FRAC_BITS);
  localparam logic [COORD_W-1:0] VEHICLE_X_RST = COORD_W'(94 << FRAC_BITS);
  localparam logic [COORD_W-1:0] VEHICLE_Y_RST = COORD_W'(120 << FRAC_BITS);
  localparam logic [ARC_W-1:0]   ARC_MAX       = {ARC_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKAHEAD = 2'd0,
    CFG_VEHICLE_X = 2'd1,
    CFG_VEHICLE_Y = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LX_MUL,
    ST_LX_ADD,
    ST_LY_MUL,
    ST_LY_ADD,
    ST_PROC,
    ST_T_DIV,
    ST_CV_NUM,
    ST_CV_DEN,
    ST_CV_PREP,
    ST_CV_DIV,
    ST_CV_FIN,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/core/pplt_if.sv -----
interface pplt_in_if;
  import pplt_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [COORD_W-1:0] seg_length;
  logic               last_point;

  modport source (output valid, point_x, point_y, seg_length, last_point, input ready);
  modport sink   (input valid, point_x, point_y, seg_length, last_point, output ready);
endinterface

interface pplt_out_if;
  import pplt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [COORD_W-1:0]        target_x;
  logic [COORD_W-1:0]        target_y;
  logic signed [COORD_W-1:0] curvature;
  logic [COORD_W-1:0]        reached_dist;
  logic                      path_valid;

  modport source (output valid, target_x, target_y, curvature, reached_dist, path_valid,
                  input ready);
  modport sink   (input valid, target_x, target_y, curvature, reached_dist, path_valid,
                  output ready);
endinterface

interface pplt_cfg_if;
  import pplt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pure_pursuit_lookahead_target_core.sv -----
// pure-pursuit lookahead target and curvature, fed one path point per word
//
// channels: in_ch takes path points (position, length to the next point,
// last marker); out_ch gives one word per path, on the point marked last:
// target, reached distance, curvature, path valid. cfg_ch writes the
// lookahead distance and the vehicle position; it is always ready. the user
// must see that it is written only while no path point is being worked on; the block does not enforce it.
// timing: one shared multiplier and one restoring divider (17 steps, one
// quotient bit a cycle) under a sequencer. a plain point is taken and
// added to the arc length, a point that crosses the lookahead distance
// also runs the divider for the crossing fraction, the point after a
// crossing first does the two interpolations, and the last point runs
// two products, divider setup, 17 divider steps, finish and output load.
// in_ch is not ready while a point is in work.
// reset: configuration returns to 40.0 / 94.0 / 120.0 pixels, the path
// state is cleared and out_ch holds no word.
// stall: a finished word waits in the output register; the block keeps
// taking points and only stops before loading the next result word.
module pure_pursuit_lookahead_target_core (
  input  logic           clk,
  input  logic           rst_n,
  pplt_in_if.sink        in_ch,
  pplt_out_if.source     out_ch,
  pplt_cfg_if.sink       cfg_ch
);
  import pplt_pkg::*;

  state_t state_r, state_nxt;

  logic [COORD_W-1:0] lookahead_r, vehicle_x_r, vehicle_y_r;

  logic [ARC_W-1:0]   arc_r;
  logic [COORD_W-1:0] prev_x_r, prev_y_r, frac_r;
  logic               cross_r, found_r;
  logic [COORD_W-1:0] found_x_r, found_y_r;
  logic [ARC_W-1:0]   found_dist_r;

  logic [COORD_W-1:0] px_r, py_r, seg_r;
  logic               last_r;

  logic [PROD_W-1:0]  prod_r;
  logic [34:0]        num_r;
  logic [NUM_W-1:0]   rem_r;
  logic [DSH_W-1:0]   dsh_r;
  logic [QUO_W-1:0]   quo_r;
  logic [DCNT_W-1:0]  dcnt_r;

  logic [COORD_W-1:0] res_tx_r, res_ty_r, res_rd_r, res_curv_r;
  logic               res_valid_r;
  logic [D2_W-1:0]    d2_r;

  logic               out_valid_r;
  logic [COORD_W-1:0] out_tx_r, out_ty_r, out_curv_r, out_rd_r;
  logic               out_pv_r;

  // datapath helpers
  logic [ARC_W:0]       arc_sum;
  logic [ARC_W-1:0]     arc_next;
  logic                 crossing;
  logic [COORD_W-1:0]   remain;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [COORD_W:0]     dx, dy, ld;
  logic [COORD_W-1:0]   ld_mag, lerp_p0;
  logic                 ld_neg;
  logic signed [33:0]   lerp_p, lerp_s, lerp_q, lerp_r;
  logic [COORD_W-1:0]   lerp_out;
  logic [COORD_W:0]     xr, yr;
  logic                 x_neg;
  logic [COORD_W-1:0]   mag, yc;
  logic [MUL_A_W-1:0]   l6, l5, fac, den_a;
  logic [ARC_W-1:0]     reached;
  logic [D2_W-1:0]      two_r, d2;
  logic [D2_W:0]        rd_sum;
  logic [COORD_W-1:0]   rd;
  logic [NUM_W-1:0]     dividend;
  logic                 div_ge;
  logic                 q_big;
  logic [COORD_W-1:0]   curv;
  logic                 out_free;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  always_comb begin
    arc_sum  = {1'b0, arc_r} + {{(ARC_W-COORD_W+1){1'b0}}, seg_r};
    arc_next = arc_sum[ARC_W] ? ARC_MAX : arc_sum[ARC_W-1:0];
    crossing = !found_r && (arc_sum >= {{(ARC_W-COORD_W+1){1'b0}}, lookahead_r});
    remain   = ({{(ARC_W-COORD_W){1'b0}}, lookahead_r} > arc_r) ?
               (lookahead_r - arc_r[COORD_W-1:0]) : '0;

    // interpolation
    dx      = {1'b0, px_r} - {1'b0, prev_x_r};
    dy      = {1'b0, py_r} - {1'b0, prev_y_r};
    ld      = (state_r == ST_LX_MUL || state_r == ST_LX_ADD) ? dx : dy;
    ld_neg  = ld[COORD_W];
    ld_mag  = ld_neg ? COORD_W'(~ld + 1'b1) : ld[COORD_W-1:0];
    lerp_p0 = (state_r == ST_LX_ADD) ? prev_x_r : prev_y_r;
    lerp_p  = ld_neg ? -$signed({2'b0, prod_r[31:0]}) : $signed({2'b0, prod_r[31:0]});
    lerp_s  = lerp_p + 34'sd16384;
    lerp_q  = lerp_s >>> FRAC_Q;
    lerp_r  = $signed({18'b0, lerp_p0}) + lerp_q;
    if (lerp_r < 0) begin
      lerp_out = '0;
    end else if (lerp_r > 34'sd65535) begin
      lerp_out = '1;
    end else begin
      lerp_out = lerp_r[COORD_W-1:0];
    end

    // curvature operands
    xr    = {1'b0, res_tx_r} - {1'b0, vehicle_x_r};
    x_neg = xr[COORD_W];
    mag   = x_neg ? COORD_W'(~xr + 1'b1) : xr[COORD_W-1:0];
    yr    = {1'b0, vehicle_y_r} - {1'b0, res_ty_r};
    if (yr[COORD_W]) begin
      yc = '0;
    end else if (yr[COORD_W-1:0] > lookahead_r) begin
      yc = lookahead_r;
    end else begin
      yc = yr[COORD_W-1:0];
    end
    l6    = {1'b0, lookahead_r, 2'b0} + {2'b0, lookahead_r, 1'b0};
    l5    = {1'b0, lookahead_r, 2'b0} + {3'b0, lookahead_r};
    fac   = (lookahead_r == '0) ? MUL_A_W'(1) : (l6 - {3'b0, yc});
    den_a = (lookahead_r == '0) ? MUL_A_W'(1) : l5;

    // shared multiplier
    case (state_r)
      ST_LX_MUL, ST_LY_MUL: begin
        mul_a = {3'b0, frac_r};
        mul_b = {9'b0, ld_mag};
      end
      ST_CV_NUM: begin
        mul_a = fac;
        mul_b = {9'b0, mag};
      end
      ST_CV_DEN: begin
        mul_a = den_a;
        mul_b = d2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    // distance used
    reached = found_r ? found_dist_r : arc_r;
    two_r   = {reached, 1'b0};
    d2      = (two_r < {{(D2_W-COORD_W){1'b0}}, lookahead_r}) ?
              {{(D2_W-COORD_W){1'b0}}, lookahead_r} : two_r;
    rd_sum  = {1'b0, d2} + 1'b1;
    rd      = (|rd_sum[D2_W:COORD_W+1]) ? '1 : rd_sum[COORD_W:1];

    dividend = {2'b0, num_r, {CURV_SH{1'b0}}} + {7'b0, prod_r[PROD_W-1:1]};
    div_ge   = ({{(DSH_W-NUM_W){1'b0}}, rem_r} >= dsh_r);

    // saturate and sign
    if (x_neg) begin
      q_big = quo_r[QUO_W-1] || (quo_r[COORD_W-1:0] > 16'h8000);
      curv  = q_big ? 16'h8000 : COORD_W'(~quo_r[COORD_W-1:0] + 1'b1);
    end else begin
      q_big = quo_r[QUO_W-1] || (quo_r[COORD_W-1:0] > 16'h7fff);
      curv  = q_big ? 16'h7fff : quo_r[COORD_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = cross_r ? ST_LX_MUL : ST_PROC;
        end
      end
      ST_LX_MUL: state_nxt = ST_LX_ADD;
      ST_LX_ADD: state_nxt = ST_LY_MUL;
      ST_LY_MUL: state_nxt = ST_LY_ADD;
      ST_LY_ADD: state_nxt = ST_PROC;
      ST_PROC: begin
        if (last_r) begin
          state_nxt = (arc_r == '0) ? ST_EMIT : ST_CV_NUM;
        end else if (crossing && seg_r != '0) begin
          state_nxt = ST_T_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_T_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CV_NUM: state_nxt = ST_CV_DEN;
      ST_CV_DEN: state_nxt = ST_CV_PREP;
      ST_CV_PREP: state_nxt = (d2_r == '0) ? ST_EMIT : ST_CV_DIV;
      ST_CV_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = ST_CV_FIN;
        end
      end
      ST_CV_FIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookahead_r <= LOOKAHEAD_RST;
      vehicle_x_r <= VEHICLE_X_RST;
      vehicle_y_r <= VEHICLE_Y_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_LOOKAHEAD: lookahead_r <= cfg_ch.data;
        CFG_VEHICLE_X: vehicle_x_r <= cfg_ch.data;
        CFG_VEHICLE_Y: vehicle_y_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_r        <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      frac_r       <= '0;
      cross_r      <= 1'b0;
      found_r      <= 1'b0;
      found_x_r    <= '0;
      found_y_r    <= '0;
      found_dist_r <= '0;
    end else begin
      case (state_r)
        ST_LX_ADD: found_x_r <= lerp_out;
        ST_LY_ADD: begin
          found_y_r <= lerp_out;
          cross_r   <= 1'b0;
          found_r   <= 1'b1;
        end
        ST_PROC: begin
          if (last_r) begin
            arc_r        <= '0;
            prev_x_r     <= '0;
            prev_y_r     <= '0;
            frac_r       <= '0;
            cross_r      <= 1'b0;
            found_r      <= 1'b0;
            found_x_r    <= '0;
            found_y_r    <= '0;
            found_dist_r <= '0;
          end else begin
            if (crossing) begin
              frac_r       <= '0;
              found_dist_r <= {{(ARC_W-COORD_W){1'b0}}, lookahead_r};
              cross_r      <= 1'b1;
            end
            arc_r    <= arc_next;
            prev_x_r <= px_r;
            prev_y_r <= py_r;
          end
        end
        ST_T_DIV: begin
          if (dcnt_r == '0) begin
            frac_r <= {quo_r[COORD_W-2:0], div_ge};
          end
        end
        default: ;
      endcase
    end
  end

  // input word, products, divider and result
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      px_r   <= in_ch.point_x;
      py_r   <= in_ch.point_y;
      seg_r  <= in_ch.seg_length;
      last_r <= in_ch.last_point;
    end
    case (state_r)
      ST_LX_MUL, ST_LY_MUL, ST_CV_NUM: prod_r <= mul_p;
      ST_CV_DEN: begin
        num_r  <= prod_r[34:0];
        prod_r <= mul_p;
      end
      ST_PROC: begin
        rem_r  <= {{(NUM_W-COORD_W-FRAC_Q){1'b0}}, remain, {FRAC_Q{1'b0}}};
        dsh_r  <= {{(DSH_W-COORD_W-16){1'b0}}, seg_r, 16'b0};
        quo_r  <= '0;
        dcnt_r <= DCNT_W'(QUO_W - 1);
        if (last_r) begin
          res_valid_r <= (arc_r != '0);
          if (arc_r == '0) begin
            res_tx_r   <= '0;
            res_ty_r   <= '0;
            res_rd_r   <= '0;
            res_curv_r <= '0;
          end else begin
            res_tx_r <= found_r ? found_x_r : px_r;
            res_ty_r <= found_r ? found_y_r : py_r;
            res_rd_r <= rd;
          end
          d2_r <= d2;
        end
      end
      ST_CV_PREP: begin
        rem_r      <= dividend;
        dsh_r      <= {prod_r, 16'b0};
        quo_r      <= '0;
        dcnt_r     <= DCNT_W'(QUO_W - 1);
        res_curv_r <= '0;
      end
      ST_T_DIV, ST_CV_DIV: begin
        if (div_ge) begin
          rem_r <= rem_r - dsh_r[NUM_W-1:0];
        end
        quo_r  <= {quo_r[QUO_W-2:0], div_ge};
        dsh_r  <= dsh_r >> 1;
        dcnt_r <= dcnt_r - 1'b1;
      end
      ST_CV_FIN: res_curv_r <= curv;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_tx_r   <= res_tx_r;
      out_ty_r   <= res_ty_r;
      out_curv_r <= res_curv_r;
      out_rd_r   <= res_rd_r;
      out_pv_r   <= res_valid_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.target_x     = out_tx_r;
  assign out_ch.target_y     = out_ty_r;
  assign out_ch.curvature    = $signed(out_curv_r);
  assign out_ch.reached_dist = out_rd_r;
  assign out_ch.path_valid   = out_pv_r;

endmodule

// ----- rtl/core/pplt_chk.sv -----
module pplt_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pplt_pkg::COORD_W-1:0]  target_x,
  input logic [pplt_pkg::COORD_W-1:0]  target_y,
  input logic signed [pplt_pkg::COORD_W-1:0] curvature,
  input logic [pplt_pkg::COORD_W-1:0]  reached_dist,
  input logic                          path_valid
);
  import pplt_pkg::*;

  // no word comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // a stalled word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(target_x) && $stable(target_y)
      && $stable(curvature) && $stable(reached_dist) && $stable(path_valid))
    else $error("stalled output word changed");

  // an empty path gives an all-zero word
  a_empty_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !path_valid |-> target_x == '0 && target_y == '0
      && curvature == '0 && reached_dist == '0)
    else $error("empty path word not zero");

  // a taken point keeps the input busy for the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a point was taken");

endmodule

bind pure_pursuit_lookahead_target_core pplt_chk u_pplt_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .target_x     (out_ch.target_x),
  .target_y     (out_ch.target_y),
  .curvature    (out_ch.curvature),
  .reached_dist (out_ch.reached_dist),
  .path_valid   (out_ch.path_valid)
);
